### src/assert_macros.svh
// Assertion helpers shared by the sampler RTL.
// Both forms sample on the rising edge of clk and are quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define CHS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Whenever the trigger holds, the result holds in the next cycle.
`define CHS_ASSERT_NEXT(label, trig, res, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) trig |=> res) else $error(msg);

`endif

### src/chs_pkg.sv
`default_nettype none
package chs_pkg;

	// One input transaction.
	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [15:0] tangent_x;
		logic signed [15:0] tangent_y;
		logic signed [15:0] tangent_z;
		logic [15:0]        rand_u;
		logic [15:0]        rand_v;
		logic [15:0]        albedo_r;
		logic [15:0]        albedo_g;
		logic [15:0]        albedo_b;
		logic               sample_ok;
	} sample_t;

	// One result transaction.
	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [14:0]        density;
		logic [14:0]        refl_r;
		logic [14:0]        refl_g;
		logic [14:0]        refl_b;
		logic               out_ok;
	} result_t;

	// Square-root chain for cos/sin theta: 33-bit argument, 17-bit root.
	localparam int SQ_ANG_STAGES = 17;
	localparam int SQ_ANG_W      = 2 * SQ_ANG_STAGES;
	// Square-root chain for the vector length: 58-bit argument, 29-bit root.
	localparam int SQ_LEN_STAGES = 29;
	localparam int SQ_LEN_W      = 2 * SQ_LEN_STAGES;
	// Normalizing divider: 44-bit numerator, 29-bit length, 15-bit quotient.
	localparam int DIV_STAGES = 15;
	localparam int DIV_NUM_W  = 44;
	localparam int DIV_DEN_W  = SQ_LEN_STAGES;

	// Total pipeline depth from the input register to the last stage.
	localparam int LAT = 69;

	localparam logic [32:0] PI_Q31     = 33'd6746518852;
	localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
	localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

	// Reciprocals ceil(2^36 / d); exact floor division for any 30-bit value.
	localparam logic [33:0] RECIP_6  = 34'(((64'd1 << 36) + 64'd5) / 64'd6);
	localparam logic [33:0] RECIP_12 = 34'(((64'd1 << 36) + 64'd11) / 64'd12);
	localparam logic [33:0] RECIP_20 = 34'(((64'd1 << 36) + 64'd19) / 64'd20);
	localparam logic [33:0] RECIP_30 = 34'(((64'd1 << 36) + 64'd29) / 64'd30);
	localparam logic [33:0] RECIP_42 = 34'(((64'd1 << 36) + 64'd41) / 64'd42);
	localparam logic [33:0] RECIP_56 = 34'(((64'd1 << 36) + 64'd55) / 64'd56);

	// Floor of x / d, with m the reciprocal of d from the list above.
	function automatic logic [29:0] mul_recip(input logic [29:0] x, input logic [33:0] m);
		logic [63:0] p;
		p = 64'(x) * 64'(m);
		return 30'(p[63:36]);
	endfunction

	// Q0.16 value divided by pi, rounded half up.
	function automatic logic [14:0] over_pi(input logic [15:0] x);
		logic [47:0] p;
		p = 48'(x) * 48'(INV_PI_Q32) + (48'd1 << 31);
		return p[46:32];
	endfunction

endpackage
`default_nettype wire

### src/chs_delay.sv
`default_nettype none
module chs_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         adv,
	input  logic [W-1:0] data,
	output logic [W-1:0] delayed
);
	logic [W-1:0] line_q [DEPTH];

	// Shift line that moves only when the pipeline advances.
	always_ff @(posedge clk) begin
		if (adv) begin
			line_q[0] <= data;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign delayed = line_q[DEPTH-1];
endmodule
`default_nettype wire

### src/chs_sqrt_cell.sv
`default_nettype none
module chs_sqrt_cell #(
	parameter int W     = chs_pkg::SQ_LEN_W,
	parameter int SHIFT = 0
) (
	input  logic         clk,
	input  logic         adv,
	input  logic [W-1:0] rem,
	input  logic [W-1:0] root,
	output logic [W-1:0] rem_q,
	output logic [W-1:0] root_q
);
	import chs_pkg::*;

	logic [W-1:0] bit_val;
	logic [W-1:0] trial;

	assign bit_val = W'(1) << SHIFT;
	assign trial   = root + bit_val;

	// One step of the digit-by-digit integer square root.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (rem >= trial) begin
				rem_q  <= rem - trial;
				root_q <= (root >> 1) + bit_val;
			end else begin
				rem_q  <= rem;
				root_q <= root >> 1;
			end
		end
	end
endmodule
`default_nettype wire

### src/chs_div_cell.sv
`default_nettype none
module chs_div_cell #(
	parameter int NW    = chs_pkg::DIV_NUM_W,
	parameter int DW    = chs_pkg::DIV_DEN_W,
	parameter int QW    = chs_pkg::DIV_STAGES,
	parameter int SHIFT = 0
) (
	input  logic          clk,
	input  logic          adv,
	input  logic [NW-1:0] rem,
	input  logic [DW-1:0] den,
	input  logic [QW-1:0] quo,
	output logic [NW-1:0] rem_q,
	output logic [DW-1:0] den_q,
	output logic [QW-1:0] quo_q
);
	import chs_pkg::*;

	logic [NW-1:0] sub;

	assign sub = NW'(den) << SHIFT;

	// One restoring division step, settling one quotient bit.
	always_ff @(posedge clk) begin
		if (adv) begin
			den_q <= den;
			if (rem >= sub) begin
				rem_q <= rem - sub;
				quo_q <= quo | (QW'(1) << SHIFT);
			end else begin
				rem_q <= rem;
				quo_q <= quo;
			end
		end
	end
endmodule
`default_nettype wire

### src/chs_sincos.sv
`default_nettype none
module chs_sincos (
	input  logic               clk,
	input  logic               adv,
	input  logic [15:0]        turn,
	output logic signed [31:0] sin_s10,
	output logic signed [31:0] cos_s10
);
	import chs_pkg::*;

	// Q30 product, truncated.
	function automatic logic [29:0] q30_mul(input logic [29:0] a, input logic [30:0] b);
		logic [60:0] p;
		p = 61'(a) * 61'(b);
		return p[59:30];
	endfunction

	logic        swap;
	logic [13:0] red;
	logic [46:0] ang;

	// Tag bits: quadrant in [2:1], octant mirror in [0].
	logic [2:0]  tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8, tag_s9;
	logic [29:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6, x_s7;
	logic [29:0] x2_s2, x2_s3, x2_s4, x2_s5, x2_s6, x2_s7;
	logic [30:0] s_s3, c_s3, s_s5, c_s5, s_s7, c_s7;
	logic [29:0] ts_s4, tc_s4, ts_s6, tc_s6, tc_s8;
	logic [29:0] ps_s8, ps_s9;
	logic [30:0] pc_s9;
	logic [30:0] s0, c0;
	logic signed [31:0] s0s, c0s, sin_d, cos_d;

	// Fold the angle into the first octant; the mirror swaps sin and cos.
	assign swap = turn[13];
	assign red  = swap ? 14'(15'h4000 - {1'b0, turn[13:0]}) : turn[13:0];
	assign ang  = 47'(red) * 47'(PI_Q31) + 47'd32768;

	// Horner evaluation of both Taylor series, one multiply per stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= {turn[15:14], swap};
			x_s1   <= ang[45:16];

			tag_s2 <= tag_s1;
			x_s2   <= x_s1;
			x2_s2  <= q30_mul(x_s1, {1'b0, x_s1});

			tag_s3 <= tag_s2;
			x_s3   <= x_s2;
			x2_s3  <= x2_s2;
			s_s3   <= Q30_ONE - 31'(mul_recip(x2_s2, RECIP_42));
			c_s3   <= Q30_ONE - 31'(mul_recip(x2_s2, RECIP_56));

			tag_s4 <= tag_s3;
			x_s4   <= x_s3;
			x2_s4  <= x2_s3;
			ts_s4  <= q30_mul(x2_s3, s_s3);
			tc_s4  <= q30_mul(x2_s3, c_s3);

			tag_s5 <= tag_s4;
			x_s5   <= x_s4;
			x2_s5  <= x2_s4;
			s_s5   <= Q30_ONE - 31'(mul_recip(ts_s4, RECIP_20));
			c_s5   <= Q30_ONE - 31'(mul_recip(tc_s4, RECIP_30));

			tag_s6 <= tag_s5;
			x_s6   <= x_s5;
			x2_s6  <= x2_s5;
			ts_s6  <= q30_mul(x2_s5, s_s5);
			tc_s6  <= q30_mul(x2_s5, c_s5);

			tag_s7 <= tag_s6;
			x_s7   <= x_s6;
			x2_s7  <= x2_s6;
			s_s7   <= Q30_ONE - 31'(mul_recip(ts_s6, RECIP_6));
			c_s7   <= Q30_ONE - 31'(mul_recip(tc_s6, RECIP_12));

			tag_s8 <= tag_s7;
			ps_s8  <= q30_mul(x_s7, s_s7);
			tc_s8  <= q30_mul(x2_s7, c_s7);

			tag_s9 <= tag_s8;
			ps_s9  <= ps_s8;
			pc_s9  <= Q30_ONE - 31'(tc_s8 >> 1);

			sin_s10 <= sin_d;
			cos_s10 <= cos_d;
		end
	end

	// Undo the octant mirror, then rotate into the quadrant.
	assign s0  = tag_s9[0] ? pc_s9 : {1'b0, ps_s9};
	assign c0  = tag_s9[0] ? {1'b0, ps_s9} : pc_s9;
	assign s0s = $signed({1'b0, s0});
	assign c0s = $signed({1'b0, c0});

	always_comb begin
		case (tag_s9[2:1])
			2'd0: begin
				sin_d = s0s;
				cos_d = c0s;
			end
			2'd1: begin
				sin_d = c0s;
				cos_d = -s0s;
			end
			2'd2: begin
				sin_d = -s0s;
				cos_d = -c0s;
			end
			default: begin
				sin_d = -c0s;
				cos_d = s0s;
			end
		endcase
	end
endmodule
`default_nettype wire

### src/cosine_hemisphere_sampler_top.sv
`default_nettype none
`include "assert_macros.svh"
// Cosine-weighted hemisphere sampler. One sample transaction is taken every clock cycle while
// sample_stall is low, and each produces exactly one result transaction, in order. The depth
// comes mostly from the bit-per-cell chains: the square roots of u and 1 - u, the 29-cell
// square root that finds the direction length and the 15-cell divider that normalizes it.
// A result that waits on a stalled output sits in the output register; one more result is
// held in a skid register, and only then does sample_stall rise.
module cosine_hemisphere_sampler_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  chs_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_stall,
	output chs_pkg::result_t result
);
	import chs_pkg::*;

	// Delay lengths that line the side paths up with the main datapath.
	localparam int NT_DLY   = 17;
	localparam int TRIG_DLY = 7;
	localparam int BT_DLY   = 16;
	localparam int DENS_DLY = 50;
	localparam int REFL_DLY = 67;

	// Flow control.
	logic           adv;
	logic [LAT-1:0] vld_q;
	logic           out_v_q;
	logic           skid_v_q;
	result_t        out_q;
	result_t        skid_q;
	result_t        pipe_res;
	logic           out_free;

	assign adv          = !skid_v_q;
	assign sample_stall = skid_v_q;
	assign out_free     = !out_v_q || !result_stall;

	// Input register.
	sample_t sample_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= sample;
		end
	end

	// Valid bit for every pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], sample_valid};
		end
	end

	// Square roots of u and 1 - u.
	logic [SQ_ANG_W-1:0] cth_rem  [SQ_ANG_STAGES+1];
	logic [SQ_ANG_W-1:0] cth_root [SQ_ANG_STAGES+1];
	logic [SQ_ANG_W-1:0] sth_rem  [SQ_ANG_STAGES+1];
	logic [SQ_ANG_W-1:0] sth_root [SQ_ANG_STAGES+1];

	assign cth_rem[0]  = SQ_ANG_W'(sample_s1.rand_u) << 16;
	assign cth_root[0] = '0;
	assign sth_rem[0]  = SQ_ANG_W'(17'h10000 - {1'b0, sample_s1.rand_u}) << 16;
	assign sth_root[0] = '0;

	for (genvar k = 0; k < SQ_ANG_STAGES; k++) begin : g_ang_sqrt
		chs_sqrt_cell #(
			.W    (SQ_ANG_W),
			.SHIFT(2 * (SQ_ANG_STAGES - 1 - k))
		) u_cth (
			.clk   (clk),
			.adv   (adv),
			.rem   (cth_rem[k]),
			.root  (cth_root[k]),
			.rem_q (cth_rem[k+1]),
			.root_q(cth_root[k+1])
		);
		chs_sqrt_cell #(
			.W    (SQ_ANG_W),
			.SHIFT(2 * (SQ_ANG_STAGES - 1 - k))
		) u_sth (
			.clk   (clk),
			.adv   (adv),
			.rem   (sth_rem[k]),
			.root  (sth_root[k]),
			.rem_q (sth_rem[k+1]),
			.root_q(sth_root[k+1])
		);
	end

	logic [15:0] cth_s18;
	logic [16:0] sth_s18;

	assign cth_s18 = cth_root[SQ_ANG_STAGES][15:0];
	assign sth_s18 = sth_root[SQ_ANG_STAGES][16:0];

	// Azimuth sine and cosine.
	logic signed [31:0] sin_s11, cos_s11;
	logic [63:0]        trig_s18;

	chs_sincos u_sincos (
		.clk    (clk),
		.adv    (adv),
		.turn   (sample_s1.rand_v),
		.sin_s10(sin_s11),
		.cos_s10(cos_s11)
	);

	chs_delay #(.W(64), .DEPTH(TRIG_DLY)) u_trig_dly (
		.clk    (clk),
		.adv    (adv),
		.data   ({sin_s11, cos_s11}),
		.delayed(trig_s18)
	);

	// Bitangent as the cross product of normal and tangent, plus the
	// reflectance terms that need nothing else.
	logic signed [32:0] bt_s2 [3];
	logic [44:0]        refl_s2;
	logic               ok_s2;
	logic [98:0]        bt_s18;

	always_ff @(posedge clk) begin
		if (adv) begin
			bt_s2[0] <= 33'(sample_s1.normal_y) * 33'(sample_s1.tangent_z)
				- 33'(sample_s1.normal_z) * 33'(sample_s1.tangent_y);
			bt_s2[1] <= 33'(sample_s1.normal_z) * 33'(sample_s1.tangent_x)
				- 33'(sample_s1.normal_x) * 33'(sample_s1.tangent_z);
			bt_s2[2] <= 33'(sample_s1.normal_x) * 33'(sample_s1.tangent_y)
				- 33'(sample_s1.normal_y) * 33'(sample_s1.tangent_x);
			refl_s2  <= {over_pi(sample_s1.albedo_r), over_pi(sample_s1.albedo_g),
				over_pi(sample_s1.albedo_b)};
			ok_s2    <= sample_s1.sample_ok;
		end
	end

	chs_delay #(.W(99), .DEPTH(BT_DLY)) u_bt_dly (
		.clk    (clk),
		.adv    (adv),
		.data   ({bt_s2[0], bt_s2[1], bt_s2[2]}),
		.delayed(bt_s18)
	);

	logic [95:0] nt_s18;

	chs_delay #(.W(96), .DEPTH(NT_DLY)) u_nt_dly (
		.clk    (clk),
		.adv    (adv),
		.data   ({sample_s1.normal_x, sample_s1.normal_y, sample_s1.normal_z,
			sample_s1.tangent_x, sample_s1.tangent_y, sample_s1.tangent_z}),
		.delayed(nt_s18)
	);

	logic [45:0] refl_s69;

	chs_delay #(.W(46), .DEPTH(REFL_DLY)) u_refl_dly (
		.clk    (clk),
		.adv    (adv),
		.data   ({refl_s2, ok_s2}),
		.delayed(refl_s69)
	);

	// Scale the frame weights by sin and cos theta.
	logic signed [31:0] sp_s18, cp_s18;
	logic signed [49:0] pa, pb;
	logic signed [31:0] a30_s19, b30_s19, c30_s19;
	logic [14:0]        dens_s19;
	logic signed [15:0] n_s19 [3];
	logic signed [15:0] t_s19 [3];
	logic signed [32:0] b_s19 [3];

	assign sp_s18 = $signed(trig_s18[63:32]);
	assign cp_s18 = $signed(trig_s18[31:0]);
	assign pa     = 50'(cp_s18) * 50'($signed({1'b0, sth_s18}));
	assign pb     = 50'(sp_s18) * 50'($signed({1'b0, sth_s18}));

	always_ff @(posedge clk) begin
		if (adv) begin
			a30_s19  <= 32'((pa + 50'sd32768) >>> 16);
			b30_s19  <= 32'((pb + 50'sd32768) >>> 16);
			c30_s19  <= $signed({2'b00, cth_s18, 14'd0});
			dens_s19 <= over_pi(cth_s18);
			for (int i = 0; i < 3; i++) begin
				n_s19[i] <= $signed(nt_s18[95-16*i -: 16]);
				t_s19[i] <= $signed(nt_s18[47-16*i -: 16]);
				b_s19[i] <= $signed(bt_s18[98-33*i -: 33]);
			end
		end
	end

	logic [14:0] dens_s69;

	chs_delay #(.W(15), .DEPTH(DENS_DLY)) u_dens_dly (
		.clk    (clk),
		.adv    (adv),
		.data   (dens_s19),
		.delayed(dens_s69)
	);

	// Weighted frame vectors, then their sum rounded to Q24.
	logic signed [64:0] bprod [3];
	logic signed [49:0] pt_s20 [3];
	logic signed [49:0] pbb_s20 [3];
	logic signed [49:0] pn_s20 [3];
	logic signed [49:0] lsum [3];
	logic signed [29:0] l_s21 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bprod[i] = 65'(b30_s19) * 65'(b_s19[i]);
			lsum[i]  = pt_s20[i] + pbb_s20[i] + pn_s20[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pt_s20[i]  <= 50'(a30_s19) * 50'(t_s19[i]);
				pbb_s20[i] <= 50'((bprod[i] + 65'sd8192) >>> 14);
				pn_s20[i]  <= 50'(c30_s19) * 50'(n_s19[i]);
				l_s21[i]   <= 30'((lsum[i] + 50'sd524288) >>> 20);
			end
		end
	end

	// Squared length.
	logic [59:0]         sqp [3];
	logic [57:0]         sq_s22 [3];
	logic signed [29:0]  l_s22 [3];
	logic [SQ_LEN_W-1:0] sum_s23;
	logic [89:0]         l_s23;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sqp[i] = 60'(l_s21[i]) * 60'(l_s21[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s22[i] <= sqp[i][57:0];
				l_s22[i]  <= l_s21[i];
			end
			sum_s23 <= SQ_LEN_W'(sq_s22[0] + sq_s22[1] + sq_s22[2]);
			l_s23   <= {l_s22[0], l_s22[1], l_s22[2]};
		end
	end

	// Length by the square-root chain; the components wait alongside.
	logic [SQ_LEN_W-1:0] len_rem  [SQ_LEN_STAGES+1];
	logic [SQ_LEN_W-1:0] len_root [SQ_LEN_STAGES+1];
	logic [89:0]         l_s52;

	assign len_rem[0]  = sum_s23;
	assign len_root[0] = '0;

	for (genvar k = 0; k < SQ_LEN_STAGES; k++) begin : g_len_sqrt
		chs_sqrt_cell #(
			.W    (SQ_LEN_W),
			.SHIFT(2 * (SQ_LEN_STAGES - 1 - k))
		) u_len (
			.clk   (clk),
			.adv   (adv),
			.rem   (len_rem[k]),
			.root  (len_root[k]),
			.rem_q (len_rem[k+1]),
			.root_q(len_root[k+1])
		);
	end

	chs_delay #(.W(90), .DEPTH(SQ_LEN_STAGES)) u_l_dly (
		.clk    (clk),
		.adv    (adv),
		.data   (l_s23),
		.delayed(l_s52)
	);

	// Set up the rounded division of each magnitude by the length.
	logic [DIV_DEN_W-1:0] len_s52;
	logic signed [29:0]   lc [3];
	logic [29:0]          mag [3];
	logic [DIV_NUM_W-1:0] num_s53 [3];
	logic [DIV_DEN_W-1:0] den_s53;
	logic [2:0]           neg_s53;
	logic                 zero_s53;

	assign len_s52 = len_root[SQ_LEN_STAGES][DIV_DEN_W-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lc[i]  = $signed(l_s52[89-30*i -: 30]);
			mag[i] = lc[i][29] ? 30'(-lc[i]) : 30'(lc[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				num_s53[i] <= (DIV_NUM_W'(mag[i]) << 14) + DIV_NUM_W'(len_s52 >> 1);
				neg_s53[i] <= lc[i][29];
			end
			den_s53  <= len_s52;
			zero_s53 <= (len_s52 == '0);
		end
	end

	// Divider chains, one per component.
	logic [DIV_NUM_W-1:0]  dv_rem [3][DIV_STAGES+1];
	logic [DIV_DEN_W-1:0]  dv_den [3][DIV_STAGES+1];
	logic [DIV_STAGES-1:0] dv_quo [3][DIV_STAGES+1];

	for (genvar c = 0; c < 3; c++) begin : g_div
		assign dv_rem[c][0] = num_s53[c];
		assign dv_den[c][0] = den_s53;
		assign dv_quo[c][0] = '0;
		for (genvar k = 0; k < DIV_STAGES; k++) begin : g_cell
			chs_div_cell #(
				.NW   (DIV_NUM_W),
				.DW   (DIV_DEN_W),
				.QW   (DIV_STAGES),
				.SHIFT(DIV_STAGES - 1 - k)
			) u_div (
				.clk  (clk),
				.adv  (adv),
				.rem  (dv_rem[c][k]),
				.den  (dv_den[c][k]),
				.quo  (dv_quo[c][k]),
				.rem_q(dv_rem[c][k+1]),
				.den_q(dv_den[c][k+1]),
				.quo_q(dv_quo[c][k+1])
			);
		end
	end

	logic [3:0] flags_s68;

	chs_delay #(.W(4), .DEPTH(DIV_STAGES)) u_flag_dly (
		.clk    (clk),
		.adv    (adv),
		.data   ({zero_s53, neg_s53}),
		.delayed(flags_s68)
	);

	// Apply the sign; a zero-length vector gives a zero direction.
	logic signed [15:0] dir_s69 [3];
	logic [15:0]        qx [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qx[i] = {1'b0, dv_quo[i][DIV_STAGES]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (flags_s68[3]) begin
					dir_s69[i] <= '0;
				end else if (flags_s68[i]) begin
					dir_s69[i] <= $signed(~qx[i] + 16'd1);
				end else begin
					dir_s69[i] <= $signed(qx[i]);
				end
			end
		end
	end

	always_comb begin
		pipe_res.dir_x   = dir_s69[0];
		pipe_res.dir_y   = dir_s69[1];
		pipe_res.dir_z   = dir_s69[2];
		pipe_res.density = dens_s69;
		pipe_res.refl_r  = refl_s69[45:31];
		pipe_res.refl_g  = refl_s69[30:16];
		pipe_res.refl_b  = refl_s69[15:1];
		pipe_res.out_ok  = refl_s69[0];
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= adv && vld_q[LAT-1];
			end
		end else if (adv && vld_q[LAT-1]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else begin
				out_q <= pipe_res;
			end
		end else if (adv && vld_q[LAT-1]) begin
			skid_q <= pipe_res;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	// Checks on the output buffering and on the frozen pipeline.
	`CHS_ASSERT(a_skid_behind_out, skid_v_q |-> out_v_q, "Skid entry held with empty output.")
	`CHS_ASSERT_NEXT(a_skid_drain, skid_v_q && !result_stall, out_v_q && !skid_v_q, "Skid not drained.")
	`CHS_ASSERT_NEXT(a_frozen_hold, !adv, $stable(vld_q), "Pipeline moved while frozen.")
endmodule
`default_nettype wire

### sim/tb_cosine_hemisphere_sampler_top.sv
`default_nettype none
module tb_cosine_hemisphere_sampler_top;
	import chs_pkg::*;

	localparam longint unsigned ONE_Q30   = 64'd1 << 30;
	localparam longint unsigned PI_TURN   = 64'd6746518852;
	localparam longint unsigned RECIP_PI  = 64'd1367130551;
	localparam int              N_RANDOM  = 2000;
	localparam int              MAX_CYCLE = 400000;
	localparam int              DRAIN     = 200;

	typedef struct {
		sample_t s;
		bit      has_exp;
		result_t exp;
	} stim_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_stall;
	sample_t sample = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	result_t   pending_dirs[$];
	stim_row_t rows[$];
	int        mismatches = 0;
	int        checked = 0;
	int        sent = 0;
	int        cycles = 0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;
	int        hold_left = 0;

	cosine_hemisphere_sampler_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #5 clk = ~clk;

	// Integer square root, floor.
	function automatic longint unsigned root_floor(input longint unsigned x);
		longint unsigned r = 0;
		longint unsigned b = 64'h4000_0000_0000_0000;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Sine and cosine of an angle within the first octant, in Q30.
	function automatic void octant_sincos(input longint unsigned r,
			output longint unsigned sn, output longint unsigned cs);
		longint unsigned x, x2, s, c;
		x  = (r * PI_TURN + 64'd32768) >> 16;
		x2 = (x * x) >> 30;
		s  = ONE_Q30 - x2 / 42;
		s  = ONE_Q30 - ((x2 * s) >> 30) / 20;
		s  = ONE_Q30 - ((x2 * s) >> 30) / 6;
		sn = (x * s) >> 30;
		c  = ONE_Q30 - x2 / 56;
		c  = ONE_Q30 - ((x2 * c) >> 30) / 30;
		c  = ONE_Q30 - ((x2 * c) >> 30) / 12;
		c  = ONE_Q30 - ((x2 * c) >> 30) / 2;
		cs = c;
	endfunction

	function automatic longint round_sh(input longint x, input int sh);
		return (x + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	function automatic logic [14:0] div_pi(input longint unsigned x);
		return 15'((x * RECIP_PI + (64'd1 << 31)) >> 32);
	endfunction

	function automatic logic signed [15:0] unit_comp(input longint l,
			input longint unsigned len);
		longint unsigned m, q;
		m = (l < 0) ? longint'(-l) : longint'(l);
		q = (m * 16384 + len / 2) / len;
		if (l < 0)
			return (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
		return (q > 32767) ? 16'sd32767 : 16'(q);
	endfunction

	// Expected direction, density and reflectance for one sample transaction.
	function automatic result_t lambert_sample(input sample_t s);
		result_t         r;
		longint          nx, ny, nz, tx, ty, tz, bx, by, bz;
		longint          sp, cp, s0, c0, a30, b30, c30, lx, ly, lz;
		longint unsigned cth, sth, pa, pb, w, len;
		nx = s.normal_x;  ny = s.normal_y;  nz = s.normal_z;
		tx = s.tangent_x; ty = s.tangent_y; tz = s.tangent_z;
		bx = ny * tz - nz * ty;
		by = nz * tx - nx * tz;
		bz = nx * ty - ny * tx;
		cth = root_floor(longint'(s.rand_u) << 16);
		sth = root_floor((64'd65536 - s.rand_u) << 16);
		// Octant reduction of the azimuth, then quadrant sign folding.
		w = s.rand_v[13:0];
		if (w < 8192) begin
			octant_sincos(w, pa, pb);
			s0 = pa; c0 = pb;
		end else begin
			octant_sincos(16384 - w, pa, pb);
			s0 = pb; c0 = pa;
		end
		case (s.rand_v[15:14])
			2'd0: begin sp = s0; cp = c0; end
			2'd1: begin sp = c0; cp = -s0; end
			2'd2: begin sp = -s0; cp = -c0; end
			default: begin sp = -c0; cp = s0; end
		endcase
		a30 = round_sh(cp * longint'(sth), 16);
		b30 = round_sh(sp * longint'(sth), 16);
		c30 = longint'(cth << 14);
		lx = round_sh(a30 * tx + round_sh(b30 * bx, 14) + c30 * nx, 20);
		ly = round_sh(a30 * ty + round_sh(b30 * by, 14) + c30 * ny, 20);
		lz = round_sh(a30 * tz + round_sh(b30 * bz, 14) + c30 * nz, 20);
		len = root_floor(longint'(lx * lx) + longint'(ly * ly) + longint'(lz * lz));
		if (len == 0) begin
			r.dir_x = '0; r.dir_y = '0; r.dir_z = '0;
		end else begin
			r.dir_x = unit_comp(lx, len);
			r.dir_y = unit_comp(ly, len);
			r.dir_z = unit_comp(lz, len);
		end
		r.density = div_pi(cth);
		r.refl_r  = div_pi(s.albedo_r);
		r.refl_g  = div_pi(s.albedo_g);
		r.refl_b  = div_pi(s.albedo_b);
		r.out_ok  = s.sample_ok;
		return r;
	endfunction

	function automatic sample_t make_sample(input int nx, ny, nz, tx, ty, tz,
			input int u, v, ar, ag, ab, input bit ok);
		sample_t s;
		s.normal_x = 16'(nx);  s.normal_y = 16'(ny);  s.normal_z = 16'(nz);
		s.tangent_x = 16'(tx); s.tangent_y = 16'(ty); s.tangent_z = 16'(tz);
		s.rand_u = 16'(u); s.rand_v = 16'(v);
		s.albedo_r = 16'(ar); s.albedo_g = 16'(ag); s.albedo_b = 16'(ab);
		s.sample_ok = ok;
		return s;
	endfunction

	function automatic logic signed [15:0] rand_comp(input int kind);
		case (kind)
			0: return 16'($urandom);
			1: return 16'($urandom_range(32768) - 16384);
			default: return ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
		endcase
	endfunction

	// Random sample: mostly orthonormal axis frames or unit-range vectors, some raw noise.
	function automatic sample_t rand_sample();
		sample_t s;
		int      kind, na, ta;
		logic signed [15:0] sn, st;
		logic [223:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		s = raw[$bits(sample_t)-1:0];
		kind = $urandom_range(9);
		if (kind < 5) begin
			na = $urandom_range(2);
			ta = (na + 1 + $urandom_range(1)) % 3;
			sn = rand_comp(2);
			st = rand_comp(2);
			s.normal_x = (na == 0) ? sn : 16'sd0;
			s.normal_y = (na == 1) ? sn : 16'sd0;
			s.normal_z = (na == 2) ? sn : 16'sd0;
			s.tangent_x = (ta == 0) ? st : 16'sd0;
			s.tangent_y = (ta == 1) ? st : 16'sd0;
			s.tangent_z = (ta == 2) ? st : 16'sd0;
		end else if (kind < 8) begin
			s.normal_x = rand_comp(1); s.normal_y = rand_comp(1); s.normal_z = rand_comp(1);
			s.tangent_x = rand_comp(1); s.tangent_y = rand_comp(1); s.tangent_z = rand_comp(1);
		end
		return s;
	endfunction

	// Offer one transaction, with a random gap first, and hold it until it is taken.
	task automatic offer_sample(input sample_t s, input bit has_exp, input result_t e);
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample <= s;
		sample_valid <= 1'b1;
		do
			@(posedge clk);
		while (sample_stall);
		pending_dirs.push_back(has_exp ? e : lambert_sample(s));
		sent++;
	endtask

	// Receiver side: random stall, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			result_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Compare every result transaction with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_dirs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %p", result);
			end else begin
				want = pending_dirs.pop_front();
				checked++;
				if (result.dir_x !== want.dir_x || result.dir_y !== want.dir_y ||
						result.dir_z !== want.dir_z || result.density !== want.density ||
						result.refl_r !== want.refl_r || result.refl_g !== want.refl_g ||
						result.refl_b !== want.refl_b || result.out_ok !== want.out_ok) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: result %0d expected %p got %p", checked, want, result);
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLE) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycles, pending_dirs.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		result_t zero_res, axis_res;
		int      phase_len;
		zero_res = '0;
		axis_res = '0;
		axis_res.dir_x = 16'sd16384;
		axis_res.out_ok = 1'b1;
		// Directed rows: axis frame, degenerate vectors, field extremes and angle boundaries.
		rows.push_back('{make_sample(0, 0, 16384, 16384, 0, 0, 0, 0, 0, 0, 0, 1), 1, axis_res});
		rows.push_back('{make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_res});
		rows.push_back('{make_sample(0, 0, 0, 0, 0, 0, 65535, 65535, 65535, 65535, 65535, 1),
			0, zero_res});
		rows.push_back('{make_sample(0, 0, 16384, 16384, 0, 0, 65535, 0, 65535, 0, 1, 1),
			0, zero_res});
		rows.push_back('{make_sample(32767, 32767, 32767, -32768, -32768, -32768, 1, 65535,
			1, 65535, 0, 0), 0, zero_res});
		rows.push_back('{make_sample(-32768, 0, 0, 0, -32768, 0, 32768, 32768, 32768, 32767,
			32768, 1), 0, zero_res});
		rows.push_back('{make_sample(16384, 16384, 0, 0, 0, 16384, 12345, 8191, 100, 200,
			300, 1), 0, zero_res});
		rows.push_back('{make_sample(0, 16384, 0, 0, 0, -16384, 40000, 8192, 7, 8, 9, 0),
			0, zero_res});
		rows.push_back('{make_sample(0, -16384, 0, 16384, 0, 0, 20000, 16384, 65535, 0, 0, 1),
			0, zero_res});
		rows.push_back('{make_sample(0, 0, -16384, 0, 16384, 0, 50000, 24576, 0, 65535, 0, 1),
			0, zero_res});
		rows.push_back('{make_sample(16384, 0, 0, 0, 0, 16384, 3000, 32768, 0, 0, 65535, 1),
			0, zero_res});
		rows.push_back('{make_sample(0, 16384, 0, 16384, 0, 0, 60000, 49152, 1234, 5678,
			9012, 1), 0, zero_res});
		rows.push_back('{make_sample(0, 0, 16384, 0, 16384, 0, 65535, 57344, 1, 1, 1, 1),
			0, zero_res});
		rows.push_back('{make_sample(16384, 0, 0, 16384, 0, 0, 30000, 4000, 5, 5, 5, 1),
			0, zero_res});
		rows.push_back('{make_sample(5, -3, 2, 1, 1, -1, 1, 16383, 2, 3, 4, 1), 0, zero_res});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 36;
		rx_idle_pct = 81;
		foreach (rows[i])
			offer_sample(rows[i].s, rows[i].has_exp, rows[i].exp);

		// Random part in three idling phases; the last one opens with a long receiver hold-off.
		phase_len = N_RANDOM / 3;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == phase_len) begin
				tx_idle_pct = 81;
				rx_idle_pct = 36;
			end else if (i == 2 * phase_len) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				hold_left = 400;
			end
			offer_sample(rand_sample(), 0, zero_res);
		end
		sample_valid <= 1'b0;

		while (pending_dirs.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Sent %0d sample transactions (directed and random) under three stall mixes",
			sent);
		$display("and one long output hold-off; %0d results checked, %0d mismatches.",
			checked, mismatches);
		if (mismatches == 0 && pending_dirs.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
